// ----- src/two_level_write_through_fifo_cache_assert.svh -----
// ----------------------------------------------------------------------------
// two-level cache assertion macros
// implication checks on the cache clock with reset masking
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_WRITE_THROUGH_FIFO_CACHE_ASSERT_SVH
`define TWO_LEVEL_WRITE_THROUGH_FIFO_CACHE_ASSERT_SVH

// same-cycle implication
`define TLWFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLWFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tlwfc_pkg.sv -----
// ----------------------------------------------------------------------------
// tlwfc_pkg
// types and constants of the two-level write-through fifo cache
// ----------------------------------------------------------------------------
package tlwfc_pkg;

  localparam int MEM_BYTES  = 65536;
  localparam int L1_WAYS    = 2;
  localparam int L2_WAYS    = 4;
  localparam int L1_SETS    = 2;
  localparam int L2_SETS    = 4;
  localparam int LINE_WORDS = 4;

  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int MEM_WORDS = MEM_BYTES / 4;
  localparam int MW        = MEM_AW - 2;

  localparam int L1_WW    = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
  localparam int L2_WW    = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int L1_SW    = 1;
  localparam int L2_SW    = 2;
  localparam int L1_TW    = 11;
  localparam int L2_TW    = 10;
  localparam int L1_DEPTH = L1_SETS << L1_WW;
  localparam int L2_DEPTH = L2_SETS << L2_WW;

  localparam logic [15:0] ADDR_MASK = 16'(MEM_BYTES - 1);
  localparam logic        OP_READ   = 1'b0;
  localparam logic        OP_WRITE  = 1'b1;

  typedef logic [LINE_WORDS-1:0][31:0] line_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_RD,
    ST_FETCH,
    ST_FILL,
    ST_DONE
  } cache_state_t;

endpackage

// ----- src/two_level_write_through_fifo_cache.sv -----
// ----------------------------------------------------------------------------
// two_level_write_through_fifo_cache
// two-level set-associative write-through cache with fifo replacement
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   op, address, write_data
// out      output     out_valid / out_ready read_data, l1_hit, l2_hit
//
// a write goes through look and done, a read hit through look, read and done
// a read miss fetches its line by four reads on the single memory read port
// the block returns to idle before the next word is accepted
// after reset a clearing pass loads all MEM_WORDS (16384) main memory words
// the next word is accepted while a finished result waits on the output
// ----------------------------------------------------------------------------
`include "two_level_write_through_fifo_cache_assert.svh"

module two_level_write_through_fifo_cache
  import tlwfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [15:0] address,
  input  logic [31:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        l1_hit,
  output logic        l2_hit
);

  cache_state_t state, state_next;

  logic [MW-1:0]   clr_idx;
  logic            clearing;

  logic            op_q;
  logic [15:0]     addr_q;
  logic [31:0]     wdata_q;
  logic            h1_q, h2_q;
  logic [2:0]      cnt;
  line_t           line_buf;
  logic [31:0]     res_data;

  logic [L1_TW-1:0] l1_tag   [L1_SETS][L1_WAYS];
  logic             l1_valid [L1_SETS][L1_WAYS];
  logic [L1_WW-1:0] l1_fifo  [L1_SETS];
  logic [L2_TW-1:0] l2_tag   [L2_SETS][L2_WAYS];
  logic             l2_valid [L2_SETS][L2_WAYS];
  logic [L2_WW-1:0] l2_fifo  [L2_SETS];

  logic [31:0] main_mem [MEM_WORDS];
  line_t       l1_mem   [L1_DEPTH];
  line_t       l2_mem   [L2_DEPTH];
  logic [31:0] mem_rd;
  line_t       l1_rd, l2_rd;

  logic [1:0]       woff;
  logic [L1_SW-1:0] set1;
  logic [L2_SW-1:0] set2;
  logic [L1_TW-1:0] tag1;
  logic [L2_TW-1:0] tag2;
  logic             found1, found2, full1, full2;
  logic [L1_WW-1:0] w1, v1;
  logic [L2_WW-1:0] w2, v2;

  logic                     mem_we;
  logic [MW-1:0]            mem_waddr, mem_raddr;
  logic [31:0]              mem_wdata;
  logic                     l1_we, l2_we;
  logic [LINE_WORDS-1:0]    l1_wen, l2_wen;
  logic [L1_SW+L1_WW-1:0]   l1_widx;
  logic [L2_SW+L2_WW-1:0]   l2_widx;
  line_t                    l1_wline, l2_wline;
  logic                     fill1, fill2;
  logic                     res_load;

  assign woff = addr_q[3:2];
  assign set1 = addr_q[4];
  assign set2 = addr_q[5:4];
  assign tag1 = addr_q[15:5];
  assign tag2 = addr_q[15:6];

  // tag lookup and victim choice
  always_comb begin
    found1 = 1'b0;
    w1     = '0;
    for (int w = 0; w < L1_WAYS; w++) begin
      if (!found1 && l1_valid[set1][w] && l1_tag[set1][w] == tag1) begin
        found1 = 1'b1;
        w1     = L1_WW'(w);
      end
    end
    full1 = 1'b1;
    v1    = l1_fifo[set1];
    for (int w = L1_WAYS - 1; w >= 0; w--) begin
      if (!l1_valid[set1][w]) begin
        full1 = 1'b0;
        v1    = L1_WW'(w);
      end
    end
  end

  always_comb begin
    found2 = 1'b0;
    w2     = '0;
    for (int w = 0; w < L2_WAYS; w++) begin
      if (!found2 && l2_valid[set2][w] && l2_tag[set2][w] == tag2) begin
        found2 = 1'b1;
        w2     = L2_WW'(w);
      end
    end
    full2 = 1'b1;
    v2    = l2_fifo[set2];
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (!l2_valid[set2][w]) begin
        full2 = 1'b0;
        v2    = L2_WW'(w);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        if (op_q == OP_WRITE) state_next = ST_DONE;
        else if (found1 || found2) state_next = ST_RD;
        else state_next = ST_FETCH;
      end
      ST_RD: state_next = ST_DONE;
      ST_FETCH: begin
        if (cnt == 3'd4) state_next = ST_FILL;
      end
      ST_FILL: state_next = ST_DONE;
      ST_DONE: begin
        if (res_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_ready  = (state == ST_IDLE) && !clearing;
    res_load  = (state == ST_DONE) && (!out_valid || out_ready);
    mem_we    = clearing || (state == ST_LOOK && op_q == OP_WRITE);
    mem_waddr = clearing ? clr_idx : addr_q[MEM_AW-1:2];
    mem_wdata = clearing ? 32'(clr_idx) : wdata_q;
    mem_raddr = {addr_q[MEM_AW-1:4], cnt[1:0]};
    fill1     = 1'b0;
    fill2     = 1'b0;
    l1_we     = 1'b0;
    l2_we     = 1'b0;
    l1_wen    = '0;
    l2_wen    = '0;
    l1_widx   = {set1, w1};
    l2_widx   = {set2, w2};
    l1_wline  = line_buf;
    l2_wline  = line_buf;
    unique case (state)
      ST_LOOK: begin
        if (op_q == OP_WRITE) begin
          l1_we          = found1;
          l2_we          = found2;
          l1_wen[woff]   = 1'b1;
          l2_wen[woff]   = 1'b1;
          l1_wline[woff] = wdata_q;
          l2_wline[woff] = wdata_q;
        end
      end
      ST_RD: begin
        if (!h1_q) begin
          fill1    = 1'b1;
          l1_we    = 1'b1;
          l1_wen   = '1;
          l1_widx  = {set1, v1};
          l1_wline = l2_rd;
        end
      end
      ST_FILL: begin
        fill1   = 1'b1;
        fill2   = 1'b1;
        l1_we   = 1'b1;
        l2_we   = 1'b1;
        l1_wen  = '1;
        l2_wen  = '1;
        l1_widx = {set1, v1};
        l2_widx = {set2, v2};
      end
      default: begin
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (mem_we) main_mem[mem_waddr] <= mem_wdata;
    mem_rd <= main_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LINE_WORDS; k++) begin
      if (l1_we && l1_wen[k]) l1_mem[l1_widx][k] <= l1_wline[k];
      if (l2_we && l2_wen[k]) l2_mem[l2_widx][k] <= l2_wline[k];
    end
    l1_rd <= l1_mem[{set1, w1}];
    l2_rd <= l2_mem[{set2, w2}];
  end

  // control and tag state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      clearing  <= 1'b1;
      clr_idx   <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
      for (int s = 0; s < L1_SETS; s++) begin
        l1_fifo[s] <= '0;
        for (int w = 0; w < L1_WAYS; w++) l1_valid[s][w] <= 1'b0;
      end
      for (int s = 0; s < L2_SETS; s++) begin
        l2_fifo[s] <= '0;
        for (int w = 0; w < L2_WAYS; w++) l2_valid[s][w] <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == MW'(MEM_WORDS - 1)) clearing <= 1'b0;
      end
      if (res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (state == ST_FETCH) cnt <= cnt + 3'd1;
      else cnt <= '0;
      if (fill1) begin
        l1_valid[set1][v1] <= 1'b1;
        if (full1) l1_fifo[set1] <= (v1 == L1_WW'(L1_WAYS - 1)) ? '0 : v1 + 1'b1;
      end
      if (fill2) begin
        l2_valid[set2][v2] <= 1'b1;
        if (full2) l2_fifo[set2] <= (v2 == L2_WW'(L2_WAYS - 1)) ? '0 : v2 + 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q    <= op;
      addr_q  <= address & ADDR_MASK;
      wdata_q <= write_data;
    end
    if (state == ST_LOOK) begin
      h1_q     <= found1;
      h2_q     <= !found1 && found2;
      res_data <= '0;
    end
    if (state == ST_RD) res_data <= h1_q ? l1_rd[woff] : l2_rd[woff];
    if (state == ST_FETCH && cnt != 3'd0) line_buf[cnt[1:0] - 2'd1] <= mem_rd;
    if (state == ST_FILL) res_data <= line_buf[woff];
    if (fill1) l1_tag[set1][v1] <= tag1;
    if (fill2) l2_tag[set2][v2] <= tag2;
    if (res_load) begin
      read_data <= res_data;
      l1_hit    <= h1_q;
      l2_hit    <= h2_q;
    end
  end

  `TLWFC_ASSERT_NOW(a_no_accept_clear, clearing, !in_ready, "word accepted during clear")
  `TLWFC_ASSERT_NOW(a_hits_exclusive, out_valid, !(l1_hit && l2_hit), "both hit flags set")
  `TLWFC_ASSERT_NEXT(a_fetch_done, state == ST_FETCH && cnt == 3'd4, state == ST_FILL,
                     "line fetch did not end in fill")

endmodule

// ----- tb/tb_two_level_write_through_fifo_cache.sv -----
// ----------------------------------------------------------------------------
// tb_two_level_write_through_fifo_cache
// self-checking bench for the two-level write-through fifo cache: a directed
// table of accesses, then random reads and writes biased to a few hot lines,
// each result checked against a typed-in value or a behavioral cache model kept in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_two_level_write_through_fifo_cache;
  import tlwfc_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        op;
  logic [15:0] address;
  logic [31:0] write_data;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] read_data;
  logic        l1_hit;
  logic        l2_hit;

  two_level_write_through_fifo_cache i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .address(address), .write_data(write_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_data(read_data), .l1_hit(l1_hit), .l2_hit(l2_hit)
  );

  typedef struct {
    logic [31:0] data;
    logic        h1;
    logic        h2;
  } access_result_t;

  typedef struct {
    logic        op;
    logic [15:0] addr;
    logic [31:0] wdata;
    logic        known;
    logic [31:0] data;
    logic        h1;
    logic        h2;
  } access_row_t;

  // behavioral copy of the cache
  logic [31:0]      mem_words [MEM_WORDS];
  logic [L1_TW-1:0] c1_tag [L1_SETS][L1_WAYS];
  logic             c1_vld [L1_SETS][L1_WAYS];
  line_t            c1_line [L1_SETS][L1_WAYS];
  int               c1_next [L1_SETS];
  logic [L2_TW-1:0] c2_tag [L2_SETS][L2_WAYS];
  logic             c2_vld [L2_SETS][L2_WAYS];
  line_t            c2_line [L2_SETS][L2_WAYS];
  int               c2_next [L2_SETS];

  access_result_t pending_results[$];
  int errors;
  int n_words;
  int n_results;
  int n_reads;
  bit calm;

  function automatic int pick_l1_way(int s);
    int w;
    for (w = 0; w < L1_WAYS; w++) if (!c1_vld[s][w]) return w;
    w = c1_next[s];
    c1_next[s] = (w + 1) % L1_WAYS;
    return w;
  endfunction

  function automatic int pick_l2_way(int s);
    int w;
    for (w = 0; w < L2_WAYS; w++) if (!c2_vld[s][w]) return w;
    w = c2_next[s];
    c2_next[s] = (w + 1) % L2_WAYS;
    return w;
  endfunction

  function automatic access_result_t cache_access(logic o, logic [15:0] a_in,
                                                  logic [31:0] wd);
    access_result_t r;
    logic [15:0] a;
    int wo, s1, s2, w1, w2, v;
    logic [L1_TW-1:0] t1;
    logic [L2_TW-1:0] t2;
    line_t ln;
    a  = a_in & ADDR_MASK;
    wo = int'(a[3:2]);
    s1 = int'(a[4]);
    s2 = int'(a[5:4]);
    t1 = a[15:5];
    t2 = a[15:6];
    w1 = -1;
    w2 = -1;
    for (int w = 0; w < L1_WAYS; w++)
      if (w1 < 0 && c1_vld[s1][w] && c1_tag[s1][w] == t1) w1 = w;
    for (int w = 0; w < L2_WAYS; w++)
      if (w2 < 0 && c2_vld[s2][w] && c2_tag[s2][w] == t2) w2 = w;
    r.data = '0;
    r.h1 = (w1 >= 0);
    r.h2 = (w1 < 0 && w2 >= 0);
    if (o == OP_WRITE) begin
      mem_words[a[15:2]] = wd;
      if (w1 >= 0) c1_line[s1][w1][wo] = wd;
      if (w2 >= 0) c2_line[s2][w2][wo] = wd;
    end else if (w1 >= 0) begin
      r.data = c1_line[s1][w1][wo];
    end else if (w2 >= 0) begin
      r.data = c2_line[s2][w2][wo];
      ln = c2_line[s2][w2];
      v = pick_l1_way(s1);
      c1_tag[s1][v] = t1; c1_vld[s1][v] = 1'b1; c1_line[s1][v] = ln;
    end else begin
      for (int k = 0; k < LINE_WORDS; k++) ln[k] = mem_words[{a[15:4], 2'(k)}];
      r.data = ln[wo];
      v = pick_l1_way(s1);
      c1_tag[s1][v] = t1; c1_vld[s1][v] = 1'b1; c1_line[s1][v] = ln;
      v = pick_l2_way(s2);
      c2_tag[s2][v] = t2; c2_vld[s2][v] = 1'b1; c2_line[s2][v] = ln;
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_results);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("Simulation FAILED");
    $finish;
  end

  // result checking and output stalls
  initial begin
    access_result_t e;
    int stall;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          report("unexpected read_data", read_data, 32'h0);
        end else begin
          e = pending_results.pop_front();
          if (read_data !== e.data) report("read_data", read_data, e.data);
          if (l1_hit !== e.h1) report("l1_hit", 32'(l1_hit), 32'(e.h1));
          if (l2_hit !== e.h2) report("l2_hit", 32'(l2_hit), 32'(e.h2));
        end
      end
      if (calm || rst) out_ready <= 1'b1;
      else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 16);
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  task automatic send_word(logic o, logic [15:0] a, logic [31:0] wd);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= o;
    address    <= a;
    write_data <= wd;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(cache_access(o, a, wd));
    n_words++;
    if (o == OP_READ) n_reads++;
  endtask

  access_row_t rows[$];

  initial begin
    access_row_t rw;
    logic [15:0] hot[8];
    logic [15:0] a;
    int cnt;
    errors = 0; n_words = 0; n_results = 0; n_reads = 0; calm = 0;
    rst = 1'b1; in_valid = 1'b0; op = OP_READ; address = '0; write_data = '0;
    for (int i = 0; i < MEM_WORDS; i++) mem_words[i] = i;
    for (int s = 0; s < L1_SETS; s++) begin
      c1_next[s] = 0;
      for (int w = 0; w < L1_WAYS; w++) c1_vld[s][w] = 1'b0;
    end
    for (int s = 0; s < L2_SETS; s++) begin
      c2_next[s] = 0;
      for (int w = 0; w < L2_WAYS; w++) c2_vld[s][w] = 1'b0;
    end
    // op, address, write data, known, data, l1 hit, l2 hit
    rows = '{
      '{OP_READ,  16'h0000, 32'h0, 1, 32'h0000_0000, 0, 0},
      '{OP_READ,  16'h0007, 32'h0, 1, 32'h0000_0001, 1, 0},
      '{OP_READ,  16'hFFFF, 32'h0, 1, 32'h0000_3FFF, 0, 0},
      '{OP_READ,  16'hFFF0, 32'h0, 1, 32'h0000_3FFC, 1, 0},
      '{OP_WRITE, 16'h0004, 32'hFFFF_FFFF, 1, 32'h0, 1, 0},
      '{OP_READ,  16'h0005, 32'h0, 1, 32'hFFFF_FFFF, 1, 0},
      '{OP_WRITE, 16'h1230, 32'hA5A5_5A5A, 1, 32'h0, 0, 0},
      '{OP_READ,  16'h1232, 32'h0, 1, 32'hA5A5_5A5A, 0, 0},
      '{OP_WRITE, 16'hFFFC, 32'h0000_0000, 1, 32'h0, 1, 0},
      '{OP_READ,  16'h0020, 32'h0, 0, 0, 0, 0},
      '{OP_READ,  16'h0040, 32'h0, 0, 0, 0, 0},
      '{OP_READ,  16'h0060, 32'h0, 0, 0, 0, 0},
      '{OP_READ,  16'h0080, 32'h0, 0, 0, 0, 0},
      '{OP_READ,  16'h0100, 32'h0, 0, 0, 0, 0},
      '{OP_READ,  16'h0000, 32'h0, 0, 0, 0, 0},
      '{OP_WRITE, 16'h0040, 32'h1234_5678, 0, 0, 0, 0},
      '{OP_READ,  16'h0040, 32'h0, 0, 0, 0, 0},
      '{OP_READ,  16'h0140, 32'h0, 0, 0, 0, 0},
      '{OP_READ,  16'h0180, 32'h0, 0, 0, 0, 0},
      '{OP_READ,  16'h01C0, 32'h0, 0, 0, 0, 0},
      '{OP_READ,  16'h0040, 32'h0, 0, 0, 0, 0},
      '{OP_READ,  16'h000C, 32'h0, 0, 0, 0, 0}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) begin
      rw = rows[i];
      // typed-in results go in place of the model's
      send_word(rw.op, rw.addr, rw.wdata);
      if (rw.known) begin
        pending_results[$].data = rw.data;
        pending_results[$].h1   = rw.h1;
        pending_results[$].h2   = rw.h2;
      end
    end
    for (int i = 0; i < 8; i++) hot[i] = 16'($urandom);
    for (int i = 0; i < 1300; i++) begin
      if (i == 1150) calm = 1;
      if ($urandom_range(0, 3) != 0) a = hot[$urandom_range(0, 7)] ^ 16'($urandom_range(0, 15));
      else if ($urandom_range(0, 1) != 0) a = {7'($urandom), 9'(hot[$urandom_range(0, 7)])};
      else a = 16'($urandom);
      if ($urandom_range(0, 40) == 0) hot[$urandom_range(0, 7)] = 16'($urandom);
      send_word(($urandom_range(0, 2) == 0) ? OP_WRITE : OP_READ, a, $urandom);
    end
    in_valid <= 1'b0;
    cnt = 0;
    while (pending_results.size() != 0 && cnt < 100000) begin
      @(posedge clk);
      cnt++;
    end
    repeat (20) @(posedge clk);
    $display("%0d words sent (%0d reads), %0d results checked", n_words, n_reads, n_results);
    if (errors == 0 && pending_results.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/tlwfc_pkg.sv
src/two_level_write_through_fifo_cache.sv
tb/tb_two_level_write_through_fifo_cache.sv
